[rtl/dfr_pkg.sv]
package dfr_pkg;

   // field widths
   localparam int unsigned OP_W    = 2;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned FLEN_W  = 7;
   localparam int unsigned TICK_W  = 16;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned STAT_W  = 2;
   localparam int unsigned CSR_A_W = 2;
   localparam int unsigned CSR_D_W = 16;

   // packed word widths on the streams
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned REQ_USER_W = OP_W;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned RSP_USER_W = 1;

   // default largest frame
   localparam int unsigned MAX_FRAME_DEF = 64;

   // register reset values
   localparam logic [BYTE_W-1:0] START_CHAR_RST    = 8'd2;
   localparam logic [BYTE_W-1:0] END_CHAR_RST      = 8'd13;
   localparam logic [FLEN_W-1:0] FRAME_LENGTH_RST  = 7'd64;
   localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd1000;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // completion status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_OVERRUN = 2'd1,
      ST_TIMEOUT = 2'd2,
      ST_FORMAT  = 2'd3
   } status_type;

   // register indexes
   typedef enum logic [CSR_A_W-1:0] {
      REG_START_CHAR    = 2'd0,
      REG_END_CHAR      = 2'd1,
      REG_FRAME_LENGTH  = 2'd2,
      REG_TIMEOUT_TICKS = 2'd3
   } reg_idx_type;

   // receiver phase, one-hot
   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_HUNT    = 3'b010,
      PH_COLLECT = 3'b100
   } phase_type;

endpackage

[rtl/delimited_frame_receiver_unit.sv]
// Channel  Dir  Handshake           Payload
// req      in   req_tvalid/tready   tuser: operation; tdata: rx_byte
// rsp      out  rsp_tvalid/tready   tuser: byte_valid; tdata: position, frame_byte,
//                                   status; tlast: frame_done
// csr      in   csr_we              csr_addr: register index; csr_wdata: value
//
// One word per cycle sustained while rsp is not stalled. A word is held in the
// input register, then decoded against the phase and counters and, if it gives a
// result, lands in the result register.
// The result register and the input register form a two-entry path, so a
// stalled rsp holds at most one word in each before req_tready drops.
// Synchronous reset returns the receiver to idle and the registers to defaults.
module delimited_frame_receiver_unit
   import dfr_pkg::*;
#(
   parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] rx_byte
   input  logic [REQ_USER_W-1:0] req_tuser,   // [1:0] operation
   // result stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] position, [13:6] frame_byte,
                                              // [15:14] status
   output logic [RSP_USER_W-1:0] rsp_tuser,   // [0] byte_valid
   output logic                  rsp_tlast,   // frame_done
   // register writes
   input  logic                  csr_we,
   input  logic [CSR_A_W-1:0]    csr_addr,
   input  logic [CSR_D_W-1:0]    csr_wdata
);

   localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
   localparam int unsigned CMP_W = (CNT_W > FLEN_W) ? CNT_W : FLEN_W;

   // configuration registers
   logic [BYTE_W-1:0] start_char_ff;
   logic [BYTE_W-1:0] end_char_ff;
   logic [FLEN_W-1:0] frame_length_ff;
   logic [TICK_W-1:0] timeout_ticks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_char_ff    <= START_CHAR_RST;
         end_char_ff      <= END_CHAR_RST;
         frame_length_ff  <= FRAME_LENGTH_RST;
         timeout_ticks_ff <= TIMEOUT_TICKS_RST;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_addr))
            REG_START_CHAR:    start_char_ff    <= csr_wdata[BYTE_W-1:0];
            REG_END_CHAR:      end_char_ff      <= csr_wdata[BYTE_W-1:0];
            REG_FRAME_LENGTH:  frame_length_ff  <= csr_wdata[FLEN_W-1:0];
            REG_TIMEOUT_TICKS: timeout_ticks_ff <= csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   logic              in_valid_ff;
   logic [OP_W-1:0]   in_op_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              advance;

   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser[OP_W-1:0];
         in_byte_ff <= req_tdata[BYTE_W-1:0];
      end
   end

   // receiver state
   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [TICK_W-1:0] elapsed_ff, elapsed_in;

   // effective frame length, clamped to 1..MAX_FRAME
   logic [CMP_W-1:0] flen_ext;
   logic [CMP_W-1:0] eff_len;
   logic [CMP_W-1:0] count_nx;
   logic [TICK_W-1:0] ticks_sat;

   assign flen_ext  = CMP_W'(frame_length_ff);
   assign eff_len   = (flen_ext == '0) ? CMP_W'(1) :
                      (flen_ext > CMP_W'(MAX_FRAME)) ? CMP_W'(MAX_FRAME) : flen_ext;
   assign count_nx  = CMP_W'(byte_count_ff) + CMP_W'(1);
   assign ticks_sat = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TICK_W'(1);

   // result of the word in the input register
   logic              res_valid;
   logic              res_byte_valid;
   logic [POS_W-1:0]  res_pos;
   logic [BYTE_W-1:0] res_byte;
   logic              res_done;
   status_type        res_status;

   always_comb begin
      phase_in       = phase_ff;
      byte_count_in  = byte_count_ff;
      elapsed_in     = elapsed_ff;
      res_valid      = 1'b0;
      res_byte_valid = 1'b0;
      res_pos        = '0;
      res_byte       = '0;
      res_done       = 1'b0;
      res_status     = ST_OK;
      case (op_type'(in_op_ff))
         OP_START: begin
            phase_in      = PH_HUNT;
            byte_count_in = '0;
            elapsed_in    = '0;
         end
         OP_TICK: begin
            if (phase_ff != PH_IDLE) begin
               elapsed_in = ticks_sat;
               if (ticks_sat >= timeout_ticks_ff) begin
                  phase_in   = PH_IDLE;
                  res_valid  = 1'b1;
                  res_done   = 1'b1;
                  res_status = ST_TIMEOUT;
               end
            end
         end
         OP_BYTE: begin
            unique case (phase_ff)
               PH_HUNT: begin
                  // start byte goes to position 0; a length of 1 ends the frame, OK only if it is also the end char
                  if (in_byte_ff == start_char_ff) begin
                     byte_count_in  = CNT_W'(1);
                     res_valid      = 1'b1;
                     res_byte_valid = 1'b1;
                     res_byte       = in_byte_ff;
                     if (eff_len == CMP_W'(1)) begin
                        phase_in   = PH_IDLE;
                        res_done   = 1'b1;
                        res_status = (in_byte_ff == end_char_ff) ? ST_OK : ST_OVERRUN;
                     end else begin
                        phase_in = PH_COLLECT;
                     end
                  end
               end
               PH_COLLECT: begin
                  byte_count_in  = count_nx[CNT_W-1:0];
                  res_valid      = 1'b1;
                  res_byte_valid = 1'b1;
                  res_pos        = POS_W'(byte_count_ff);
                  res_byte       = in_byte_ff;
                  if (count_nx == eff_len && in_byte_ff == end_char_ff) begin
                     phase_in   = PH_IDLE;
                     res_done   = 1'b1;
                     res_status = ST_OK;
                  end else if (count_nx >= eff_len) begin
                     phase_in   = PH_IDLE;
                     res_done   = 1'b1;
                     res_status = ST_OVERRUN;
                  end else if (in_byte_ff == end_char_ff) begin
                     phase_in   = PH_IDLE;
                     res_done   = 1'b1;
                     res_status = ST_FORMAT;
                  end
               end
               PH_IDLE: ;
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // result register, free when empty or being drained
   logic                  rsp_valid_ff;
   logic                  out_free;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_bv_ff;
   logic                  rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign advance  = in_valid_ff && (!res_valid || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         byte_count_ff <= '0;
         elapsed_ff    <= '0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         byte_count_ff <= byte_count_in;
         elapsed_ff    <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= advance && res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && advance && res_valid) begin
         rsp_data_ff <= {res_status, res_byte, res_pos};
         rsp_bv_ff   <= res_byte_valid;
         rsp_last_ff <= res_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_bv_ff;
   assign rsp_tlast  = rsp_last_ff;

   // a word without a frame byte is always a completion
   a_nobyte_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("result without byte is not a completion");

   // status is zero unless the attempt ends
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[15:14] == 2'd0)
      else $error("status set on a non-final word");

   // while collecting the count stays below the largest frame
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COLLECT |-> CMP_W'(byte_count_ff) < CMP_W'(MAX_FRAME))
      else $error("byte count out of range while collecting");

   // a stalled result with a pending result word blocks the input
   a_stall_block: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready && in_valid_ff && res_valid |-> !req_tready)
      else $error("input accepted while result path is full");

endmodule
